// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers shared by the RTL; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Overlapping implication, sampled on clk, disabled while rst_n is low.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- sv/qwt_pkg.sv -----
// ----------------------------------------------------------------------------
// qwt_pkg
// Types and constants shared by the quoted word tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package qwt_pkg;

    localparam int BYTE_W         = 8;
    localparam int COUNT_BITS_DEF = 8;
    localparam int MAX_RESULTS    = 3;

    localparam logic [BYTE_W-1:0] QUOTE_CH      = 8'h27;
    localparam logic [BYTE_W-1:0] BSLASH_CH     = 8'h5C;
    localparam logic [BYTE_W-1:0] MAX_TOKENS_RST = 8'd255;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_EOW  = 2'd1,
        KIND_DONE = 2'd2
    } item_kind_t;

    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_PLAIN   = 3'd1,
        MODE_QUOTED  = 3'd2,
        MODE_QSEEN   = 3'd3,
        MODE_ESCAPE  = 3'd4,
        MODE_RAW     = 3'd5,
        MODE_DROP    = 3'd6
    } scan_mode_t;

    typedef struct packed {
        item_kind_t         kind;
        logic [BYTE_W-1:0]  value;
        logic [BYTE_W-1:0]  count;
        logic               last;
    } result_t;

    // All results caused by one text byte, slot 0 first.
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] slot;
        logic    [1:0]             num;
    } res_set_t;

endpackage

`default_nettype wire

// ----- sv/quoted_word_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// quoted_word_tokenizer_core
// Splits a byte stream into words with single-quote quoting and a word limit.
// ----------------------------------------------------------------------------
// Usage:
// Text enters on the s_ channel, one byte per beat, with s_tlast on the
// final byte of a text. Results leave on the m_ channel, one per beat:
// m_tuser gives the kind (word byte, end of word, done), m_tdata carries
// the byte in its low half and the running word count in its high half,
// and m_tlast marks the last result caused by one input byte.
// An accepted byte is held in the input register, decoded by the scan logic,
// and its whole result set (zero to three beats) is written to the result
// buffer, which hands the beats out in slot order. The result buffer drains
// one beat per cycle while m_tready is high; a byte that causes at most one
// result therefore streams at one byte per cycle, and a byte with N results
// occupies the output for N beats. A byte with no result passes through the
// input register and adds no beat.
// When the receiver stalls, the buffer holds its beats and the input
// register holds the next byte; s_tready drops only while both are full.
// Reset empties both stages, returns the scanner to between words with a
// count of zero and loads max_tokens with 255. cfg_we writes max_tokens;
// the user must write it only while no text byte is in flight, unchecked here.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module quoted_word_tokenizer_core #(
    parameter int COUNT_BITS = qwt_pkg::COUNT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration: max_tokens.
    input  wire logic                          cfg_we,
    input  wire logic [qwt_pkg::BYTE_W-1:0]    cfg_wdata,
    // Text input.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [qwt_pkg::BYTE_W-1:0]    s_tdata,   // data_byte
    input  wire logic                          s_tlast,   // end_of_text
    // Result output.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [2*qwt_pkg::BYTE_W-1:0]       m_tdata,   // out_byte, word_count
    output logic                               m_tlast,   // last_result
    output logic [1:0]                         m_tuser    // item_kind
);
    import qwt_pkg::*;

    // Input register.
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_eot_reg;

    // Scanner state and configuration.
    scan_mode_t            mode_reg;
    scan_mode_t            mode_next;
    logic [COUNT_BITS-1:0] words_seen_reg;
    logic [COUNT_BITS-1:0] words_seen_next;
    logic [BYTE_W-1:0]     max_tokens_reg;

    res_set_t res_set;
    logic     buf_free;
    logic     advance;

    // The held byte moves on as soon as the result buffer has room for its set.
    assign advance  = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || buf_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_BETWEEN;
            words_seen_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg       <= mode_next;
            words_seen_reg <= words_seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tokens_reg <= MAX_TOKENS_RST;
        end
        else if (cfg_we)
        begin
            max_tokens_reg <= cfg_wdata;
        end
    end

    qwt_scan #(
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .data_byte       (in_byte_reg),
        .end_of_text     (in_eot_reg),
        .mode            (mode_reg),
        .words_seen      (words_seen_reg),
        .max_tokens      (max_tokens_reg),
        .mode_next       (mode_next),
        .words_seen_next (words_seen_next),
        .res_set         (res_set)
    );

    qwt_result_buf u_result_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .res_set  (res_set),
        .free     (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // A done beat is always the last result of its byte.
    `ASSERT_IMPLIES(a_done_is_last, m_tvalid && (m_tuser == KIND_DONE), m_tlast,
        "done beat without last_result")
    // Input backpressure only while a byte waits behind pending results.
    `ASSERT_IMPLIES(a_stall_cause, !s_tready, in_valid_reg && m_tvalid,
        "s_tready low without a full pipeline")
    // The end of a text clears the scanner.
    `ASSERT_NEXT(a_eot_clears, advance && in_eot_reg,
        (words_seen_reg == '0) && (mode_reg == MODE_BETWEEN),
        "scanner not cleared after end of text")

endmodule

`default_nettype wire

// ----- sv/qwt_scan.sv -----
// ----------------------------------------------------------------------------
// qwt_scan
// Decodes one text byte against the scan state: next state and result set.
// ----------------------------------------------------------------------------
`default_nettype none

module qwt_scan #(
    parameter int COUNT_BITS = qwt_pkg::COUNT_BITS_DEF
) (
    input  wire logic [qwt_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                       end_of_text,
    input  wire qwt_pkg::scan_mode_t        mode,
    input  wire logic [COUNT_BITS-1:0]      words_seen,
    input  wire logic [qwt_pkg::BYTE_W-1:0] max_tokens,
    output qwt_pkg::scan_mode_t             mode_next,
    output logic [COUNT_BITS-1:0]           words_seen_next,
    output qwt_pkg::res_set_t               res_set
);
    import qwt_pkg::*;

    localparam int CMP_W = (COUNT_BITS > BYTE_W) ? COUNT_BITS : BYTE_W;

    logic [BYTE_W-1:0]     limit;
    logic [COUNT_BITS-1:0] ws_inc;
    logic                  at_limit;
    logic                  at_limit_inc;
    logic                  is_space;
    logic                  is_quote;

    assign limit        = (max_tokens == '0) ? BYTE_W'(1) : max_tokens;
    assign ws_inc       = (words_seen == '1) ? words_seen : words_seen + 1'b1;
    assign at_limit     = CMP_W'(words_seen) >= CMP_W'(limit);
    assign at_limit_inc = CMP_W'(ws_inc) >= CMP_W'(limit);
    assign is_space     = (data_byte == 8'h20) || (data_byte >= 8'h09 && data_byte <= 8'h0D);
    assign is_quote     = (data_byte == QUOTE_CH);

    always_comb
    begin
        result_t   slot [MAX_RESULTS];
        logic [1:0] num;
        logic       start;

        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            slot[i] = '{kind: KIND_BYTE, value: '0, count: '0, last: 1'b0};
        end
        num             = 2'd0;
        start           = 1'b0;
        mode_next       = mode;
        words_seen_next = words_seen;

        unique case (mode)
            MODE_PLAIN:
            begin
                if (is_space)
                begin
                    slot[0]   = '{KIND_EOW, '0, BYTE_W'(words_seen), 1'b0};
                    num       = 2'd1;
                    mode_next = MODE_BETWEEN;
                end
                else if (is_quote)
                begin
                    slot[0] = '{KIND_EOW, '0, BYTE_W'(words_seen), 1'b0};
                    num     = 2'd1;
                    start   = 1'b1;
                end
                else
                begin
                    slot[0] = '{KIND_BYTE, data_byte, BYTE_W'(words_seen), 1'b0};
                    num     = 2'd1;
                end
            end
            MODE_QUOTED:
            begin
                if (is_quote)
                begin
                    mode_next = MODE_QSEEN;
                end
                else if (data_byte == BSLASH_CH)
                begin
                    mode_next = MODE_ESCAPE;
                end
                else
                begin
                    slot[0] = '{KIND_BYTE, data_byte, BYTE_W'(words_seen), 1'b0};
                    num     = 2'd1;
                end
            end
            MODE_QSEEN:
            begin
                if (is_quote)
                begin
                    // Doubled quote is a literal quote inside the word.
                    slot[0]   = '{KIND_BYTE, data_byte, BYTE_W'(words_seen), 1'b0};
                    num       = 2'd1;
                    mode_next = MODE_QUOTED;
                end
                else
                begin
                    slot[0] = '{KIND_EOW, '0, BYTE_W'(words_seen), 1'b0};
                    num     = 2'd1;
                    if (at_limit)
                    begin
                        mode_next = MODE_DROP;
                    end
                    else
                    begin
                        start = 1'b1;
                    end
                end
            end
            MODE_ESCAPE:
            begin
                slot[0]   = '{KIND_BYTE, data_byte, BYTE_W'(words_seen), 1'b0};
                num       = 2'd1;
                mode_next = MODE_QUOTED;
            end
            MODE_RAW:
            begin
                slot[0] = '{KIND_BYTE, data_byte, BYTE_W'(words_seen), 1'b0};
                num     = 2'd1;
            end
            MODE_DROP:
            begin
                num = 2'd0;
            end
            default:
            begin
                start = 1'b1;
            end
        endcase

        // Word start: whitespace stays between words, the limit drops the rest.
        if (start)
        begin
            if (is_space)
            begin
                mode_next = MODE_BETWEEN;
            end
            else if (at_limit)
            begin
                mode_next = MODE_DROP;
            end
            else
            begin
                words_seen_next = ws_inc;
                if (is_quote)
                begin
                    mode_next = MODE_QUOTED;
                end
                else
                begin
                    slot[num] = '{KIND_BYTE, data_byte, BYTE_W'(ws_inc), 1'b0};
                    num       = num + 2'd1;
                    mode_next = at_limit_inc ? MODE_RAW : MODE_PLAIN;
                end
            end
        end

        if (end_of_text)
        begin
            slot[num]       = '{KIND_DONE, '0, BYTE_W'(words_seen_next), 1'b0};
            num             = num + 2'd1;
            mode_next       = MODE_BETWEEN;
            words_seen_next = '0;
        end

        if (num != 2'd0)
        begin
            slot[num - 2'd1].last = 1'b1;
        end

        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res_set.slot[i] = slot[i];
        end
        res_set.num = num;
    end

endmodule

`default_nettype wire

// ----- sv/qwt_result_buf.sv -----
// ----------------------------------------------------------------------------
// qwt_result_buf
// Holds one byte's result set; sends one beat per cycle while m_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module qwt_result_buf (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load,
    input  wire qwt_pkg::res_set_t            res_set,
    output logic                              free,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [2*qwt_pkg::BYTE_W-1:0]      m_tdata,  // out_byte, word_count
    output logic                              m_tlast,  // last_result
    output logic [1:0]                        m_tuser   // item_kind
);
    import qwt_pkg::*;

    result_t    slot_reg [MAX_RESULTS];
    logic [1:0] rem_reg;
    logic [1:0] rem_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    result_t    head;

    assign head     = slot_reg[idx_reg];
    assign m_tvalid = (rem_reg != 2'd0);
    assign m_tdata  = {head.count, head.value};
    assign m_tlast  = head.last;
    assign m_tuser  = head.kind;
    // Room for a new set once the last pending beat leaves this cycle.
    assign free     = (rem_reg == 2'd0) || (rem_reg == 2'd1 && m_tready);

    always_comb
    begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (load)
        begin
            rem_next = res_set.num;
            idx_next = 2'd0;
        end
        else if (m_tvalid && m_tready)
        begin
            rem_next = rem_reg - 2'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                slot_reg[i] <= res_set.slot[i];
            end
        end
    end

endmodule

`default_nettype wire
